[design/smpq_pkg.sv]
// Shared constants, codes and item types of the sorted minimum priority queue.
`default_nettype none
package smpq_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_POP    = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef logic signed [VALUE_WIDTH-1:0] entry_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;

    typedef struct packed {
        action_t            action;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        status_t            status;
        logic [4:0]         occupancy;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;
    } cmd_t;

    // Incoming value: low VALUE_WIDTH bits of the zero-extended 32-bit field.
    function automatic entry_t to_entry(logic [31:0] raw);
        logic [63:0] wide;
        wide = {32'b0, raw};
        return entry_t'(wide[VALUE_WIDTH-1:0]);
    endfunction

    // Stored entry sign-extended, then cut to the 32-bit result field.
    function automatic logic [31:0] to_field(entry_t e);
        logic signed [63:0] wide;
        wide = 64'(e);
        return wide[31:0];
    endfunction

endpackage
`default_nettype wire

[design/smpq_ctrl.sv]
// Controller: result register occupancy and item acceptance.
`default_nettype none
module smpq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output smpq_pkg::cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_VACANT = 2'b01,
        S_HELD   = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // A new item may enter while the held result is being taken.
    assign req_ready = (state_reg == S_VACANT) || rsp_ready;
    assign rsp_valid = (state_reg == S_HELD);
    assign cmd.exec  = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_VACANT:
            begin
                if (cmd.exec)
                    state_next = S_HELD;
            end
            S_HELD:
            begin
                if (rsp_ready && !cmd.exec)
                    state_next = S_VACANT;
            end
            default: state_next = S_VACANT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_VACANT;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

[design/smpq_datapath.sv]
// Datapath: sorted entry cells with parallel compare-and-shift, count, result register.
`default_nettype none
module smpq_datapath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire smpq_pkg::cmd_t cmd,
    input  wire smpq_pkg::req_t req,
    output smpq_pkg::rsp_t      rsp
);

    localparam int N = smpq_pkg::CAPACITY;

    smpq_pkg::entry_t entries_reg [N];
    smpq_pkg::entry_t entries_next [N];
    smpq_pkg::count_t count_reg, count_next;
    smpq_pkg::rsp_t   rsp_reg, rsp_next;

    smpq_pkg::entry_t v;
    logic [N-1:0]     le;
    logic             is_full;
    logic             is_empty;

    assign v        = smpq_pkg::to_entry(req.value);
    assign is_full  = (count_reg >= smpq_pkg::count_t'(N));
    assign is_empty = (count_reg == '0);

    // Stored prefix that is <= v; the new value lands just behind it.
    always_comb
    begin
        for (int i = 0; i < N; i++)
            le[i] = (smpq_pkg::count_t'(i) < count_reg) && (entries_reg[i] <= v);
    end

    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        rsp_next     = rsp_reg;
        if (cmd.exec)
        begin
            rsp_next.popped_value = '0;
            rsp_next.status       = smpq_pkg::ST_DONE;
            if (req.action == smpq_pkg::ACT_POP)
            begin
                if (is_empty)
                begin
                    rsp_next.status = smpq_pkg::ST_EMPTY;
                end
                else
                begin
                    rsp_next.popped_value = smpq_pkg::to_field(entries_reg[0]);
                    for (int i = 0; i < N - 1; i++)
                        entries_next[i] = entries_reg[i+1];
                    count_next = count_reg - smpq_pkg::count_t'(1);
                end
            end
            else
            begin
                if (is_full)
                begin
                    rsp_next.status = smpq_pkg::ST_FULL;
                end
                else
                begin
                    if (le[0])
                        entries_next[0] = entries_reg[0];
                    else
                        entries_next[0] = v;
                    for (int i = 1; i < N; i++)
                    begin
                        if (le[i])
                            entries_next[i] = entries_reg[i];
                        else if (le[i-1])
                            entries_next[i] = v;
                        else
                            entries_next[i] = entries_reg[i-1];
                    end
                    count_next = count_reg + smpq_pkg::count_t'(1);
                end
            end
            rsp_next.occupancy = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule
`default_nettype wire

[design/sorted_min_priority_queue.sv]
// Top level of the sorted minimum priority queue.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  req     | req_valid / req_ready  | req_t: action, value
//  rsp     | rsp_valid / rsp_ready  | rsp_t: popped_value, status, occupancy
//
// Each item is resolved in the cycle it is accepted by one parallel
// compare-and-shift across all entry cells; its result appears in the
// result register next cycle; one item per cycle while rsp_ready is high.
// A new item is accepted while the held result is taken in the same cycle.
// Reset empties the queue at once; entry contents are left as they are.
// A stalled result holds req_ready low until it is taken.
`default_nettype none
module sorted_min_priority_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire smpq_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output smpq_pkg::rsp_t      rsp
);

    smpq_pkg::cmd_t cmd;

    smpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    smpq_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire

[tb/sv/smpq_sb_pkg.sv]
// Scoreboard for the sorted minimum priority queue: shadow store and awaited results.
package smpq_sb_pkg;

    import smpq_pkg::*;

    class min_queue_scoreboard;
        entry_t sorted_copy[$];
        rsp_t   awaited[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        // Apply one accepted item to the shadow store and queue its result.
        function void note_request(req_t item);
            rsp_t   res;
            entry_t v;
            int     pos;
            res.popped_value = '0;
            res.status       = ST_DONE;
            if (item.action == ACT_POP) begin
                if (sorted_copy.size() == 0)
                    res.status = ST_EMPTY;
                else
                    res.popped_value = to_field(sorted_copy.pop_front());
            end
            else if (sorted_copy.size() >= CAPACITY) begin
                res.status = ST_FULL;
            end
            else begin
                v   = to_entry(item.value);
                pos = 0;
                // new value goes behind every stored value <= it
                while (pos < sorted_copy.size() && sorted_copy[pos] <= v)
                    pos++;
                sorted_copy.insert(pos, v);
            end
            res.occupancy = 5'(sorted_copy.size());
            awaited.push_back(res);
        endfunction

        function void report(string what, rsp_t exp_r, rsp_t got);
            if (errors < 10)
                $display("%s: exp val=%0d st=%0d occ=%0d, got val=%0d st=%0d occ=%0d",
                         what, exp_r.popped_value, exp_r.status, exp_r.occupancy,
                         got.popped_value, got.status, got.occupancy);
            errors++;
        endfunction

        function void check_response(rsp_t got);
            rsp_t exp_r;
            if (awaited.size() == 0) begin
                exp_r = '0;
                report("unexpected result", exp_r, got);
                return;
            end
            exp_r = awaited.pop_front();
            if (got.popped_value !== exp_r.popped_value || got.status !== exp_r.status ||
                got.occupancy !== exp_r.occupancy)
                report("result mismatch", exp_r, got);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

endpackage

[tb/sv/tb_top.sv]
// Top-level testbench of the sorted minimum priority queue.
module tb_top;

    import smpq_pkg::*;
    import smpq_sb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 600;

    bit   clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    min_queue_scoreboard sb;

    int burst_left    = 0;
    int hold_requests = 0;
    int cycle_count   = 0;

    sorted_min_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
            sb.note_request(req);
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
    end

    // Receiver: random stretches of stall modes, plus long hold-offs on request.
    initial
    begin
        int hold_served;
        int hold_left;
        int stretch_left;
        int stall_mode;
        hold_served  = 0;
        hold_left    = 0;
        stretch_left = 0;
        stall_mode   = 0;
        rsp_ready    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stall_mode   = $urandom_range(0, 2);
                    stretch_left = $urandom_range(5, 60);
                end
                stretch_left--;
                case (stall_mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    default: rsp_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic req_t make_req(action_t act, logic signed [31:0] val);
        req_t item;
        item.action = act;
        item.value  = val;
        return item;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $signed(32'($urandom_range(0, 8))) - 32'sd4;
            3:       return $signed(32'($urandom_range(0, 100)));
            default: return $urandom;
        endcase
    endfunction

    // Offer one item; the sender idles for a random gap between bursts.
    task automatic offer(req_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            repeat (gap)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic drain_all();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    initial
    begin
        logic signed [31:0] fill_values [16];
        int pop_pct;
        int phase_left;
        sb         = new();
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        pop_pct    = 50;
        phase_left = 0;
        fill_values = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1, 32'sd5,
                        32'sd5, 32'sd5, -32'sd5, 32'sh7FFF_FFFE, 32'sh8000_0001,
                        32'shAAAA_AAAA, 32'sh5555_5555, 32'sd5, 32'sh0, -32'sd1};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: pop on empty, fill with extremes and equals, insert when full
        offer(make_req(ACT_POP, 32'sh1234_5678));
        foreach (fill_values[i])
            offer(make_req(ACT_INSERT, fill_values[i]));
        offer(make_req(ACT_INSERT, 32'sd12345));
        repeat (4) offer(make_req(ACT_POP, $urandom));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       pop_pct = 25;
                    1:       pop_pct = 75;
                    default: pop_pct = 50;
                endcase
                phase_left = $urandom_range(10, 60);
            end
            phase_left--;
            if (n == 200)
                hold_requests++;
            if (n == 400)
                drain_all();
            if ($urandom_range(0, 99) < pop_pct)
                offer(make_req(ACT_POP, $urandom));
            else
                offer(make_req(ACT_INSERT, pick_value()));
        end

        drain_all();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
design/smpq_pkg.sv
design/smpq_ctrl.sv
design/smpq_datapath.sv
design/sorted_min_priority_queue.sv
tb/sv/smpq_sb_pkg.sv
tb/sv/tb_top.sv
